/* rtl/core/dpf_pkg.sv */
// Shared types and constants of the demand paging fault handler.
// Used by the interfaces, the page table, the frame cells and the top level.
// Depends on nothing else.
package dpf_pkg;

	// Sizes of the tracked region and of the frame pool.
	localparam int MAX_PAGES  = 256;
	localparam int MAX_FRAMES = 16;

	// Internal widths that follow from the sizes.
	localparam int PAGE_W  = $clog2(MAX_PAGES);
	localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
	localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);

	// Fixed widths of the port fields.
	localparam int ADDR_W    = 48;
	localparam int SHIFT_W   = 5;
	localparam int PCFG_W    = 9;
	localparam int FCFG_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int ACTION_W  = 2;
	localparam int PIDX_W    = 8;
	localparam int FIDX_W    = 4;
	localparam int PROT_W    = 2;

	// Configuration register indexes.
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_REGION_BASE  = 2'd0;
	localparam cfg_idx_t CFG_PAGE_SHIFT   = 2'd1;
	localparam cfg_idx_t CFG_PAGES_IN_USE = 2'd2;
	localparam cfg_idx_t CFG_FRAMES_IN_USE = 2'd3;

	// Page state codes.
	typedef logic [1:0] pg_state_t;
	localparam pg_state_t PG_UNALLOC = 2'd0;
	localparam pg_state_t PG_IN_RAM  = 2'd1;
	localparam pg_state_t PG_IN_SWAP = 2'd2;

	// Action codes of a result.
	typedef logic [ACTION_W-1:0] action_t;
	localparam action_t ACT_IGNORE    = 2'd0;
	localparam action_t ACT_ZERO_FILL = 2'd1;
	localparam action_t ACT_WRITABLE  = 2'd2;
	localparam action_t ACT_SWAP_IN   = 2'd3;

	// Protection codes of a result.
	typedef logic [PROT_W-1:0] prot_t;
	localparam prot_t PROT_NO = 2'd0;
	localparam prot_t PROT_RD = 2'd1;
	localparam prot_t PROT_RW = 2'd2;

	// One page table entry.
	typedef struct packed {
		pg_state_t            state;
		pg_state_t            prev;
		logic                 dirty;
		logic [FRAME_W-1:0]   frame;
	} pte_t;

	// Access to the page table for one cycle.
	typedef struct packed {
		logic                 wr_en;
		logic [PAGE_W-1:0]    wr_addr;
		pte_t                 wr_data;
		logic [PAGE_W-1:0]    rd_addr;
	} pt_req_t;

	// Broadcast control to the row of frame cells.
	typedef struct packed {
		logic                 start;
		logic                 set;
		logic [FRAME_W-1:0]   frame;
		logic [PAGE_W-1:0]    page;
	} fc_ctrl_t;

	// Status of one frame cell while the scan token sits in it.
	typedef struct packed {
		logic                 hit;
		logic                 stop;
	} fc_stat_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_RANGE,
		ST_LOOK,
		ST_SCAN,
		ST_EVICT,
		ST_FILL,
		ST_DONE
	} fsm_t;

endpackage

/* rtl/core/dpf_ifs.sv */
// Channel interfaces of the demand paging fault handler: fault requests,
// results and configuration writes.
// Depends on dpf_pkg.
interface dpf_req_if;
	logic                         valid;
	logic                         ready;
	logic [dpf_pkg::ADDR_W-1:0]   fault_addr;

	modport source(output valid, output fault_addr, input ready);
	modport sink(input valid, input fault_addr, output ready);
endinterface

interface dpf_res_if;
	logic                         valid;
	logic                         ready;
	logic [dpf_pkg::ACTION_W-1:0] action;
	logic [dpf_pkg::PIDX_W-1:0]   page_index;
	logic [dpf_pkg::FIDX_W-1:0]   frame_index;
	logic                         evicted;
	logic [dpf_pkg::PIDX_W-1:0]   evicted_page;
	logic                         write_back;
	logic [dpf_pkg::PROT_W-1:0]   new_protection;

	modport source(output valid, output action, output page_index, output frame_index,
		output evicted, output evicted_page, output write_back, output new_protection,
		input ready);
	modport sink(input valid, input action, input page_index, input frame_index,
		input evicted, input evicted_page, input write_back, input new_protection,
		output ready);
endinterface

interface dpf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dpf_pkg::CFG_IDX_W-1:0] index;
	logic [dpf_pkg::ADDR_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/core/dpf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.
module dpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/dpf_page_table.sv */
// Page table: one entry per page held in a RAM, with a valid bit per entry
// so that entries never written read as unallocated and clean.
// Depends on dpf_pkg and dpf_ram.
module dpf_page_table (
	input  logic             clk,
	input  logic             arst_n,
	input  dpf_pkg::pt_req_t req,
	output dpf_pkg::pte_t    rd_ent
);

	logic [dpf_pkg::MAX_PAGES-1:0] vld_q;
	logic                          rd_vld_q;
	logic [$bits(dpf_pkg::pte_t)-1:0] ram_rdata;
	dpf_pkg::pte_t                 ram_ent;

	dpf_ram #(
		.WIDTH($bits(dpf_pkg::pte_t)),
		.DEPTH(dpf_pkg::MAX_PAGES)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	// Valid bits: cleared at reset, set by the first write of an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[req.rd_addr];
		end
	end

	// An entry never written reads as unallocated and clean; its frame is never used.
	always_comb begin
		ram_ent = ram_rdata;
		rd_ent  = ram_ent;
		if (!rd_vld_q) begin
			rd_ent.state = dpf_pkg::PG_UNALLOC;
			rd_ent.prev  = dpf_pkg::PG_UNALLOC;
			rd_ent.dirty = 1'b0;
		end
	end

endmodule

/* rtl/core/dpf_frame_cell.sv */
// One frame cell: holds the valid mark and owning page of one physical
// frame, and passes the free-frame scan token on to the next cell.
// Depends on dpf_pkg.
module dpf_frame_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpf_pkg::fc_ctrl_t            ctrl,
	input  logic [dpf_pkg::FRAME_W-1:0]  cell_idx,
	input  logic [dpf_pkg::FCNT_W-1:0]   frame_cnt,
	input  logic                         tok_in,
	output logic                         tok_out,
	output dpf_pkg::fc_stat_t            stat,
	output logic [dpf_pkg::PAGE_W-1:0]   owner
);

	logic                        valid_q;
	logic                        tok_q;
	logic [dpf_pkg::PAGE_W-1:0]  owner_q;
	logic                        in_lim;
	logic                        sel;

	assign in_lim = dpf_pkg::FCNT_W'(cell_idx) < frame_cnt;
	assign sel    = ctrl.set && (ctrl.frame == cell_idx);

	// The token stops here on a free frame or past the frame count.
	assign stat.hit  = tok_q && in_lim && !valid_q;
	assign stat.stop = tok_q && !in_lim;
	assign tok_out   = tok_q && in_lim && valid_q;
	assign owner     = owner_q;

	// Control state: scan token and the frame's valid mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Owning page of the frame.
	always_ff @(posedge clk) begin
		if (sel) begin
			owner_q <= ctrl.page;
		end
	end

endmodule

/* rtl/core/demand_paging_fault_handler.sv */
// Top level of the demand paging fault handler: sequencer, configuration
// registers, page table, row of frame cells and result register.
// Depends on dpf_pkg, dpf_ifs, dpf_page_table and dpf_frame_cell.
//
// Usage: each request on fault_req carries one faulting address. Exactly one
// result per request leaves on result: ignored (outside the region), a
// zero-filled read-only map, a read-only swap-in or a grant of write access,
// with the frame used and, when frame 0 had to be reclaimed, the evicted page
// and whether it must be written back. Configuration goes through cfg, which
// is always ready; the user must see that it is written only while no request
// is in flight, as the block itself does not enforce this. The free-frame
// search walks a token along the frame cells, one cell a cycle. One request
// is handled at a time; the next is accepted in the cycle after the result is
// loaded. The result register holds a finished result while the receiver
// stalls; the next request is taken meanwhile and waits at its end until that
// register is free. Reset empties the page table and all frames and returns
// the registers to their defaults; the block is ready at once.
module demand_paging_fault_handler (
	input  logic      clk,
	input  logic      arst_n,
	dpf_req_if.sink   fault_req,
	dpf_res_if.source result,
	dpf_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [dpf_pkg::ADDR_W-1:0]  base_q;
	logic [dpf_pkg::SHIFT_W-1:0] shift_q;
	logic [dpf_pkg::PCFG_W-1:0]  pages_q;
	logic [dpf_pkg::FCFG_W-1:0]  frames_q;

	// Sequencer and working registers.
	dpf_pkg::fsm_t               state_q, state_d;
	logic [dpf_pkg::ADDR_W-1:0]  addr_q;
	logic [dpf_pkg::ADDR_W-1:0]  diff_q;
	logic                        ge_q;
	logic [dpf_pkg::PAGE_W-1:0]  page_q;
	dpf_pkg::pte_t               ent_q;
	logic [dpf_pkg::FRAME_W-1:0] frame_sel_q;

	// Result being built.
	dpf_pkg::action_t            r_action_q;
	logic [dpf_pkg::PAGE_W-1:0]  r_page_q;
	logic [dpf_pkg::FRAME_W-1:0] r_frame_q;
	logic                        r_ev_q;
	logic [dpf_pkg::PAGE_W-1:0]  r_evp_q;
	logic                        r_wb_q;
	dpf_pkg::prot_t              r_prot_q;

	// Result register.
	logic                        out_vld_q;
	dpf_pkg::action_t            out_action_q;
	logic [dpf_pkg::PIDX_W-1:0]  out_page_q;
	logic [dpf_pkg::FIDX_W-1:0]  out_frame_q;
	logic                        out_ev_q;
	logic [dpf_pkg::PIDX_W-1:0]  out_evp_q;
	logic                        out_wb_q;
	dpf_pkg::prot_t              out_prot_q;

	// Combinational signals.
	logic                        req_acc;
	logic                        out_load;
	logic [dpf_pkg::ADDR_W-1:0]  idx;
	logic [dpf_pkg::PCNT_W-1:0]  eff_pages;
	logic [dpf_pkg::FCNT_W-1:0]  eff_frames;
	logic                        in_range;
	dpf_pkg::pt_req_t            pt_req;
	dpf_pkg::pte_t               pt_rd;
	dpf_pkg::fc_ctrl_t           fc_ctrl;
	dpf_pkg::fc_stat_t           fc_stat [dpf_pkg::MAX_FRAMES];
	logic [dpf_pkg::MAX_FRAMES:0] tok;
	logic [dpf_pkg::MAX_FRAMES-1:0] hits;
	logic [dpf_pkg::MAX_FRAMES-1:0] stops;
	logic [dpf_pkg::FRAME_W-1:0] hit_idx;
	logic                        any_hit;
	logic                        exhausted;
	logic [dpf_pkg::PAGE_W-1:0]  owner0;

	assign req_acc         = fault_req.valid && fault_req.ready;
	assign fault_req.ready = (state_q == dpf_pkg::ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign out_load        = (state_q == dpf_pkg::ST_DONE) && (!out_vld_q || result.ready);

	// Effective page and frame counts.
	always_comb begin
		if (32'(pages_q) > dpf_pkg::MAX_PAGES) begin
			eff_pages = dpf_pkg::PCNT_W'(dpf_pkg::MAX_PAGES);
		end else begin
			eff_pages = dpf_pkg::PCNT_W'(pages_q);
		end
		if (frames_q == '0) begin
			eff_frames = dpf_pkg::FCNT_W'(1);
		end else if (32'(frames_q) > dpf_pkg::MAX_FRAMES) begin
			eff_frames = dpf_pkg::FCNT_W'(dpf_pkg::MAX_FRAMES);
		end else begin
			eff_frames = dpf_pkg::FCNT_W'(frames_q);
		end
	end

	// Page number within the region and range check.
	assign idx      = diff_q >> shift_q;
	assign in_range = ge_q && (idx < dpf_pkg::ADDR_W'(eff_pages));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			shift_q  <= dpf_pkg::SHIFT_W'(12);
			pages_q  <= dpf_pkg::PCFG_W'(256);
			frames_q <= dpf_pkg::FCFG_W'(16);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				dpf_pkg::CFG_REGION_BASE:   base_q   <= cfg.data;
				dpf_pkg::CFG_PAGE_SHIFT:    shift_q  <= cfg.data[dpf_pkg::SHIFT_W-1:0];
				dpf_pkg::CFG_PAGES_IN_USE:  pages_q  <= cfg.data[dpf_pkg::PCFG_W-1:0];
				dpf_pkg::CFG_FRAMES_IN_USE: frames_q <= cfg.data[dpf_pkg::FCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Page table.
	dpf_page_table u_pt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (pt_req),
		.rd_ent(pt_rd)
	);

	// Row of frame cells; the scan token enters at frame 0.
	assign tok[0] = fc_ctrl.start;

	for (genvar k = 0; k < dpf_pkg::MAX_FRAMES; k++) begin : g_cell
		if (k == 0) begin : g_first
			dpf_frame_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (fc_ctrl),
				.cell_idx (dpf_pkg::FRAME_W'(k)),
				.frame_cnt(eff_frames),
				.tok_in   (tok[k]),
				.tok_out  (tok[k+1]),
				.stat     (fc_stat[k]),
				.owner    (owner0)
			);
		end else begin : g_rest
			dpf_frame_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (fc_ctrl),
				.cell_idx (dpf_pkg::FRAME_W'(k)),
				.frame_cnt(eff_frames),
				.tok_in   (tok[k]),
				.tok_out  (tok[k+1]),
				.stat     (fc_stat[k]),
				.owner    ()
			);
		end
	end

	// Collect where the token stopped; only one cell holds it at a time.
	always_comb begin
		hit_idx = '0;
		for (int k = 0; k < dpf_pkg::MAX_FRAMES; k++) begin
			hits[k]  = fc_stat[k].hit;
			stops[k] = fc_stat[k].stop;
			if (fc_stat[k].hit) begin
				hit_idx = hit_idx | dpf_pkg::FRAME_W'(k);
			end
		end
	end

	assign any_hit   = |hits;
	assign exhausted = (|stops) || tok[dpf_pkg::MAX_FRAMES];

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, page table accesses and frame cell control.
	always_comb begin
		state_d = state_q;
		pt_req  = '0;
		pt_req.rd_addr = page_q;
		fc_ctrl = '0;
		unique case (state_q)
			dpf_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = dpf_pkg::ST_DIFF;
				end
			end
			dpf_pkg::ST_DIFF: begin
				state_d = dpf_pkg::ST_RANGE;
			end
			dpf_pkg::ST_RANGE: begin
				pt_req.rd_addr = dpf_pkg::PAGE_W'(idx);
				state_d = in_range ? dpf_pkg::ST_LOOK : dpf_pkg::ST_DONE;
			end
			dpf_pkg::ST_LOOK: begin
				case (pt_rd.state) inside
					dpf_pkg::PG_IN_RAM: begin
						pt_req.wr_en         = 1'b1;
						pt_req.wr_addr       = page_q;
						pt_req.wr_data       = pt_rd;
						pt_req.wr_data.dirty = 1'b1;
						state_d = dpf_pkg::ST_DONE;
					end
					dpf_pkg::PG_UNALLOC, dpf_pkg::PG_IN_SWAP: begin
						fc_ctrl.start = 1'b1;
						state_d = dpf_pkg::ST_SCAN;
					end
					default: begin
						state_d = dpf_pkg::ST_DONE;
					end
				endcase
			end
			dpf_pkg::ST_SCAN: begin
				if (any_hit) begin
					state_d = dpf_pkg::ST_FILL;
				end else if (exhausted) begin
					pt_req.rd_addr = owner0;
					state_d = dpf_pkg::ST_EVICT;
				end
			end
			dpf_pkg::ST_EVICT: begin
				// The reclaimed page goes to swap, clean, remembering its state.
				pt_req.wr_en         = 1'b1;
				pt_req.wr_addr       = r_evp_q;
				pt_req.wr_data.state = dpf_pkg::PG_IN_SWAP;
				pt_req.wr_data.prev  = pt_rd.state;
				pt_req.wr_data.dirty = 1'b0;
				pt_req.wr_data.frame = pt_rd.frame;
				state_d = dpf_pkg::ST_FILL;
			end
			dpf_pkg::ST_FILL: begin
				pt_req.wr_en         = 1'b1;
				pt_req.wr_addr       = page_q;
				pt_req.wr_data.state = dpf_pkg::PG_IN_RAM;
				pt_req.wr_data.prev  = ent_q.state;
				pt_req.wr_data.dirty = (ent_q.state == dpf_pkg::PG_IN_SWAP) ?
					1'b0 : ent_q.dirty;
				pt_req.wr_data.frame = frame_sel_q;
				fc_ctrl.set   = 1'b1;
				fc_ctrl.frame = frame_sel_q;
				fc_ctrl.page  = page_q;
				state_d = dpf_pkg::ST_DONE;
			end
			dpf_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = dpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpf_pkg::ST_IDLE;
			end
		endcase
	end

	// Working registers and result being built.
	always_ff @(posedge clk) begin
		case (state_q)
			dpf_pkg::ST_IDLE: begin
				if (req_acc) begin
					addr_q <= fault_req.fault_addr;
				end
			end
			dpf_pkg::ST_DIFF: begin
				ge_q   <= addr_q >= base_q;
				diff_q <= addr_q - base_q;
			end
			dpf_pkg::ST_RANGE: begin
				page_q     <= dpf_pkg::PAGE_W'(idx);
				r_action_q <= dpf_pkg::ACT_IGNORE;
				r_page_q   <= '0;
				r_frame_q  <= '0;
				r_ev_q     <= 1'b0;
				r_evp_q    <= '0;
				r_wb_q     <= 1'b0;
				r_prot_q   <= dpf_pkg::PROT_NO;
			end
			dpf_pkg::ST_LOOK: begin
				ent_q <= pt_rd;
				if (pt_rd.state == dpf_pkg::PG_IN_RAM) begin
					r_action_q <= dpf_pkg::ACT_WRITABLE;
					r_page_q   <= page_q;
					r_frame_q  <= pt_rd.frame;
					r_prot_q   <= dpf_pkg::PROT_RW;
				end
			end
			dpf_pkg::ST_SCAN: begin
				if (any_hit) begin
					frame_sel_q <= hit_idx;
				end else if (exhausted) begin
					frame_sel_q <= '0;
					r_ev_q      <= 1'b1;
					r_evp_q     <= owner0;
				end
			end
			dpf_pkg::ST_EVICT: begin
				r_wb_q <= (pt_rd.prev == dpf_pkg::PG_UNALLOC) || pt_rd.dirty;
			end
			dpf_pkg::ST_FILL: begin
				r_action_q <= (ent_q.state == dpf_pkg::PG_UNALLOC) ?
					dpf_pkg::ACT_ZERO_FILL : dpf_pkg::ACT_SWAP_IN;
				r_page_q   <= page_q;
				r_frame_q  <= frame_sel_q;
				r_prot_q   <= dpf_pkg::PROT_RD;
			end
			default: ;
		endcase
	end

	// Result register: holds a finished result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_action_q <= r_action_q;
			out_page_q   <= dpf_pkg::PIDX_W'(r_page_q);
			out_frame_q  <= dpf_pkg::FIDX_W'(r_frame_q);
			out_ev_q     <= r_ev_q;
			out_evp_q    <= dpf_pkg::PIDX_W'(r_evp_q);
			out_wb_q     <= r_wb_q;
			out_prot_q   <= r_prot_q;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.action         = out_action_q;
	assign result.page_index     = out_page_q;
	assign result.frame_index    = out_frame_q;
	assign result.evicted        = out_ev_q;
	assign result.evicted_page   = out_evp_q;
	assign result.write_back     = out_wb_q;
	assign result.new_protection = out_prot_q;

	// The scan token is never in two cells at once.
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits | stops))
		else $error("free-frame scan token found in more than one cell");

	// A reclaim always hands out frame 0 to a newly mapped page.
	a_evict_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.evicted |->
			result.frame_index == '0 &&
			(result.action == dpf_pkg::ACT_ZERO_FILL || result.action == dpf_pkg::ACT_SWAP_IN))
		else $error("eviction reported without a fresh mapping of frame 0");

	// Write-back is only ordered for an evicted page.
	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.write_back |-> result.evicted)
		else $error("write-back ordered without an eviction");

	// An ignored fault carries no other information.
	a_ignore_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.action == dpf_pkg::ACT_IGNORE |->
			result.page_index == '0 && result.frame_index == '0 && !result.evicted &&
			result.evicted_page == '0 && !result.write_back &&
			result.new_protection == dpf_pkg::PROT_NO)
		else $error("ignored fault with non-zero result fields");

	// A frame is only claimed at the end of a scan that found or freed it.
	a_set_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fc_ctrl.set |->
			$past(state_q) == dpf_pkg::ST_SCAN || $past(state_q) == dpf_pkg::ST_EVICT)
		else $error("frame claimed without a preceding scan");

endmodule
